>>> hw/rtl/psrs_pkg.sv
// psrs_pkg: shared constants, payload structs and control/status types
`default_nettype none
package psrs_pkg;

  // table geometry and field widths
  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_BITS   = 16;
  localparam int ADDR_W       = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = 26;
  localparam int ELEM_W       = 16;
  localparam int INDEX_W      = 10;
  localparam int ELEM_COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SUM    = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [ELEM_W-1:0]    elem_value;
    logic [INDEX_W-1:0]   query_index;
    logic [SUM_W-1:0]     search_target;
  } in_t;

  typedef struct packed {
    logic [SUM_W-1:0]        answer;
    logic                    error_flag;
    logic [ELEM_COUNT_W-1:0] elem_count;
  } out_t;

  // what the result register captures when an item finishes
  typedef enum logic [1:0] {
    FIN_ZERO  = 2'd0,
    FIN_ERR   = 2'd1,
    FIN_RDATA = 2'd2,
    FIN_LO    = 2'd3
  } fin_sel_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     append;
    logic     rd_query;
    logic     search_init;
    logic     probe;
    logic     step;
    logic     fin;
    fin_sel_t fin_sel;
  } psrs_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    idx_bad;
    logic    search_bad;
    logic    lo_lt_hi;
  } psrs_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/psrs_ram.sv
// psrs_ram: generic single-write, single-read RAM with registered read data
`default_nettype none
module psrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/psrs_datapath.sv
// psrs_datapath: table memory, count and total, search bounds, result register
`default_nettype none
module psrs_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psrs_pkg::in_t       in_item,
  input  wire psrs_pkg::psrs_cmd_t cmd,
  output psrs_pkg::psrs_stat_t     stat,
  output psrs_pkg::out_t           out_item
);
  import psrs_pkg::*;

  in_t               in_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [ADDR_W-1:0]  lo_r, hi_r, mid_r, mid;
  logic [ADDR_W-1:0]  raddr;
  logic [SUM_W-1:0]   rdata;
  out_t               out_r;

  // saturating running total for an append
  assign sum_wide = {1'b0, total_r} + (SUM_W+1)'(in_r.elem_value[VALUE_BITS-1:0]);
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  assign mid   = lo_r + ((hi_r - lo_r) >> 1);
  assign raddr = cmd.probe ? mid : ADDR_W'(in_r.query_index);

  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    if (cmd.clear) begin
      count_nxt = '0;
      total_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + COUNT_W'(1);
      total_nxt = sum_sat;
    end
  end

  psrs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (sum_sat),
    .re    (cmd.rd_query | cmd.probe),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_item;
    end
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= ADDR_W'(count_r - COUNT_W'(1));
    end else if (cmd.step) begin
      if (rdata >= in_r.search_target) begin
        hi_r <= mid_r;
      end else begin
        lo_r <= mid_r + ADDR_W'(1);
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
    if (cmd.fin) begin
      out_r.error_flag <= (cmd.fin_sel == FIN_ERR);
      out_r.elem_count <= ELEM_COUNT_W'(count_nxt);
      unique case (cmd.fin_sel)
        FIN_ZERO:  out_r.answer <= '0;
        FIN_ERR:   out_r.answer <= '0;
        FIN_RDATA: out_r.answer <= rdata;
        FIN_LO:    out_r.answer <= SUM_W'(lo_r);
        default:   out_r.answer <= '0;
      endcase
    end
  end

  assign stat.op         = in_r.opcode;
  assign stat.full       = (count_r >= COUNT_W'(MAX_ELEMENTS));
  assign stat.idx_bad    = ((COUNT_W+1)'(in_r.query_index) >= (COUNT_W+1)'(count_r));
  assign stat.search_bad = (count_r == '0) || (in_r.search_target > total_r);
  assign stat.lo_lt_hi   = (lo_r < hi_r);

  assign out_item = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/psrs_ctrl.sv
// psrs_ctrl: sequencer for one item at a time, issues datapath commands
`default_nettype none
module psrs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      out_valid,
  input  wire psrs_pkg::psrs_stat_t stat,
  output psrs_pkg::psrs_cmd_t       cmd
);
  import psrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUM_WAIT,
    S_SRCH,
    S_PROBE_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.fin     = 1'b1;
            cmd.fin_sel = FIN_ZERO;
            state_nxt   = S_IDLE;
          end
          OP_APPEND: begin
            cmd.append  = !stat.full;
            cmd.fin     = 1'b1;
            if (stat.full) begin
              cmd.fin_sel = FIN_ERR;
            end else begin
              cmd.fin_sel = FIN_ZERO;
            end
            state_nxt   = S_IDLE;
          end
          OP_SUM: begin
            if (stat.idx_bad) begin
              cmd.fin     = 1'b1;
              cmd.fin_sel = FIN_ERR;
              state_nxt   = S_IDLE;
            end else begin
              cmd.rd_query = 1'b1;
              state_nxt    = S_SUM_WAIT;
            end
          end
          OP_SEARCH: begin
            if (stat.search_bad) begin
              cmd.fin     = 1'b1;
              cmd.fin_sel = FIN_ERR;
              state_nxt   = S_IDLE;
            end else begin
              cmd.search_init = 1'b1;
              state_nxt       = S_SRCH;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SUM_WAIT: begin
        cmd.fin     = 1'b1;
        cmd.fin_sel = FIN_RDATA;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        if (stat.lo_lt_hi) begin
          cmd.probe = 1'b1;
          state_nxt = S_PROBE_WAIT;
        end else begin
          cmd.fin     = 1'b1;
          cmd.fin_sel = FIN_LO;
          state_nxt   = S_IDLE;
        end
      end
      S_PROBE_WAIT: begin
        cmd.step  = 1'b1;
        state_nxt = S_SRCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.fin;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/prefix_sum_rank_select.sv
// prefix_sum_rank_select: top level of the prefix-sum table with sum and search queries
//
// Holds up to MAX_ELEMENTS appended values as stored inclusive prefix sums in
// one single-port-read table RAM. An item is transferred when start is high
// and busy is low; its result appears on out_item for exactly one cycle with
// out_valid high, and the receiver cannot stall it, so it must take the result
// in that cycle. Clear, append and any rejected query finish in S_EXEC; a
// prefix-sum query reads the table in S_EXEC and is finished in S_SUM_WAIT,
// and a search probes once per halving of the bounds: each binary-search
// probe issues the table read in S_SRCH, and the registered read data comes
// back in S_PROBE_WAIT to narrow the bounds. A new item may be transferred in
// the same cycle the previous result is shown. The table needs no clearing
// after reset: only entries below the stored count are ever read.
`default_nettype none
module prefix_sum_rank_select (
  input  wire logic           clk,
  input  wire logic           rst_n,
  // input channel
  input  wire logic           start,
  output logic                busy,
  input  wire psrs_pkg::in_t  in_item,
  // result channel
  output logic                out_valid,
  output psrs_pkg::out_t      out_item
);
  import psrs_pkg::*;

  // command and status between sequencer and datapath
  psrs_cmd_t  cmd;
  psrs_stat_t stat;

  // sequencer: decodes the opcode, walks the binary search, strobes the result
  psrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: table ram, count and total, search bounds, result register
  psrs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking testbench for the prefix-sum table with sum and search queries
`default_nettype none
module tb;
  import psrs_pkg::*;

  // largest total a full table of maximum values can reach
  localparam int unsigned MaxTarget = MAX_ELEMENTS * ((1 << VALUE_BITS) - 1);
  // generous ceiling: every item with a long sender gap and a full-depth search
  localparam int unsigned CycleLimit = 400000;
  // quiet cycles after the last result before the verdict
  localparam int unsigned DrainCycles = 30;
  // the mixed sequence phase runs until this many items have been sent in all
  localparam int unsigned MixedItems = 870;

  // mirror of the table: predicts the result of every transferred item and
  // holds the predictions until the block shows them
  class answer_checker;
    logic [SUM_W-1:0] prefix_mem [MAX_ELEMENTS];
    int unsigned      held;
    logic [SUM_W-1:0] total;
    out_t             answers_due [$];
    int unsigned      errors;

    function new();
      held   = 0;
      total  = '0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return answers_due.size();
    endfunction

    function void take_item(in_t it);
      out_t        exp;
      longint      sum;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      exp = '0;
      case (it.opcode)
        OP_CLEAR: begin
          held  = 0;
          total = '0;
        end
        OP_APPEND: begin
          if (held >= MAX_ELEMENTS) begin
            exp.error_flag = 1'b1;
          end else begin
            sum = longint'(total) + longint'(it.elem_value);
            if (sum > longint'((64'd1 << SUM_W) - 1)) sum = (64'd1 << SUM_W) - 1;
            total                          = sum[SUM_W-1:0];
            prefix_mem[held[ADDR_W-1:0]] = sum[SUM_W-1:0];
            held++;
          end
        end
        OP_SUM: begin
          if (it.query_index >= held) exp.error_flag = 1'b1;
          else exp.answer = prefix_mem[it.query_index];
        end
        default: begin
          if (held == 0 || it.search_target > total) begin
            exp.error_flag = 1'b1;
          end else begin
            lo = 0;
            hi = held - 1;
            while (lo < hi) begin
              mid = lo + (hi - lo) / 2;
              if (prefix_mem[mid[ADDR_W-1:0]] >= it.search_target) hi = mid;
              else lo = mid + 1;
            end
            exp.answer = SUM_W'(lo);
          end
        end
      endcase
      exp.elem_count = held[ELEM_COUNT_W-1:0];
      answers_due.push_back(exp);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_answer(out_t got);
      out_t exp;
      if (answers_due.size() == 0) begin
        report_mismatch("result with no item outstanding");
        return;
      end
      exp = answers_due.pop_front();
      if (got.answer !== exp.answer)
        report_mismatch($sformatf("answer got %0d want %0d", got.answer, exp.answer));
      if (got.error_flag !== exp.error_flag)
        report_mismatch($sformatf("error_flag got %b want %b",
                                  got.error_flag, exp.error_flag));
      if (got.elem_count !== exp.elem_count)
        report_mismatch($sformatf("elem_count got %0d want %0d",
                                  got.elem_count, exp.elem_count));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_item = '0;
  logic out_valid;
  out_t out_item;

  answer_checker board;
  int unsigned   cycle_count = 0;
  int unsigned   sent = 0;
  // when set, the sender offers items back to back
  bit            burst = 1'b0;

  prefix_sum_rank_select i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a lost result or a stuck busy ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_answer(out_item);
  end

  // item of the given opcode with arg in its operand field; the unused fields
  // carry random content so the block must ignore them
  function automatic in_t make_item(opcode_t op, int unsigned arg);
    in_t it;
    it.opcode        = op;
    it.elem_value    = ELEM_W'($urandom);
    it.query_index   = INDEX_W'($urandom);
    it.search_target = SUM_W'($urandom_range(0, MaxTarget));
    case (op)
      OP_APPEND: it.elem_value    = arg[ELEM_W-1:0];
      OP_SUM:    it.query_index   = arg[INDEX_W-1:0];
      OP_SEARCH: it.search_target = arg[SUM_W-1:0];
      default: ;
    endcase
    return it;
  endfunction

  // element values lean on zero, the maximum and small values
  function automatic int unsigned pick_value();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return (1 << VALUE_BITS) - 1;
      2:       return $urandom_range(0, 15);
      default: return $urandom_range(0, (1 << VALUE_BITS) - 1);
    endcase
  endfunction

  // mostly a held index, now and then anything the field allows
  function automatic int unsigned pick_index();
    if (board.held > 0 && $urandom_range(0, 7) != 0)
      return $urandom_range(0, board.held - 1);
    return $urandom_range(0, (1 << INDEX_W) - 1);
  endfunction

  // search targets around the stored prefix sums and the total
  function automatic int unsigned pick_target();
    int unsigned       tot;
    int unsigned       k;
    logic [ADDR_W-1:0] pos;
    tot = 32'(board.total);
    if (board.held == 0) return $urandom_range(0, MaxTarget);
    pos = ADDR_W'($urandom_range(0, board.held - 1));
    k   = 32'(board.prefix_mem[pos]);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return tot;
      2:       return (tot < MaxTarget) ? tot + 1 : tot;
      3:       return k;
      4:       return (k < MaxTarget) ? k + 1 : k;
      5:       return $urandom_range(0, MaxTarget);
      default: return $urandom_range(0, tot);
    endcase
  endfunction

  // one transfer: optional wait for all results, random gap, then hold start
  // until busy is low at an edge; start stays high into a zero-gap next item
  task automatic send_item(input in_t it, input bit drain);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap != 0 || drain) start <= 1'b0;
    if (drain) begin
      do @(posedge clk); while (board.outstanding() != 0);
    end
    repeat (gap) @(posedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.take_item(it);
    sent++;
  endtask

  task automatic send_query();
    if ($urandom_range(0, 1) == 0) send_item(make_item(OP_SUM, pick_index()), 1'b0);
    else send_item(make_item(OP_SEARCH, pick_target()), 1'b0);
  endtask

  initial begin
    int unsigned n;
    int unsigned r;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: queries on an empty table, extreme values, range edges
    send_item(make_item(OP_SEARCH, 0), 1'b0);
    send_item(make_item(OP_SUM, 0), 1'b0);
    send_item(make_item(OP_APPEND, 0), 1'b0);
    send_item(make_item(OP_APPEND, (1 << VALUE_BITS) - 1), 1'b0);
    send_item(make_item(OP_APPEND, 1), 1'b0);
    send_item(make_item(OP_APPEND, 12345), 1'b0);
    send_item(make_item(OP_SUM, 0), 1'b0);
    send_item(make_item(OP_SUM, 3), 1'b0);
    // index at and far past the count
    send_item(make_item(OP_SUM, 4), 1'b0);
    send_item(make_item(OP_SUM, (1 << INDEX_W) - 1), 1'b0);
    // zero target hits the leading zero element
    send_item(make_item(OP_SEARCH, 0), 1'b0);
    send_item(make_item(OP_SEARCH, 1), 1'b0);
    send_item(make_item(OP_SEARCH, (1 << VALUE_BITS) - 1), 1'b0);
    send_item(make_item(OP_SEARCH, 1 << VALUE_BITS), 1'b0);
    send_item(make_item(OP_SEARCH, 32'(board.total)), 1'b0);
    // target one above the total, and the largest target
    send_item(make_item(OP_SEARCH, 32'(board.total) + 1), 1'b0);
    send_item(make_item(OP_SEARCH, MaxTarget), 1'b0);
    // clear keeps the old contents but nothing below the count is left
    send_item(make_item(OP_CLEAR, 0), 1'b0);
    send_item(make_item(OP_SUM, 0), 1'b0);
    send_item(make_item(OP_SEARCH, 0), 1'b0);
    send_item(make_item(OP_APPEND, 7), 1'b0);
    send_item(make_item(OP_SUM, 0), 1'b0);
    send_item(make_item(OP_SEARCH, 7), 1'b0);

    // mixed sequences: clear, a short load, then queries with some noise
    while (sent < MixedItems) begin
      burst = ($urandom_range(0, 3) == 0);
      send_item(make_item(OP_CLEAR, 0), $urandom_range(0, 4) == 0);
      n = $urandom_range(1, 40);
      repeat (n) send_item(make_item(OP_APPEND, pick_value()), 1'b0);
      n = $urandom_range(5, 30);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r == 0)
          send_item(make_item(opcode_t'($urandom_range(0, 3)),
                              $urandom_range(0, MaxTarget)), 1'b0);
        else if (r == 1) send_item(make_item(OP_APPEND, pick_value()), 1'b0);
        else send_query();
      end
    end

    // full table of maximum values: the total reaches the largest target;
    // the sender first waits for every outstanding result
    burst = 1'b0;
    send_item(make_item(OP_CLEAR, 0), 1'b1);
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      send_item(make_item(OP_APPEND, (1 << VALUE_BITS) - 1), 1'b0);
    end
    burst = 1'b0;
    // appends into a full table are refused
    send_item(make_item(OP_APPEND, pick_value()), 1'b0);
    send_item(make_item(OP_SUM, MAX_ELEMENTS - 1), 1'b0);
    send_item(make_item(OP_SEARCH, MaxTarget), 1'b0);
    send_item(make_item(OP_SEARCH, 0), 1'b0);
    send_item(make_item(OP_SEARCH, 1), 1'b0);
    repeat (40) send_query();
    repeat (3) send_item(make_item(OP_APPEND, pick_value()), 1'b0);
    send_item(make_item(OP_CLEAR, 0), 1'b0);
    send_query();
    start <= 1'b0;

    // let every result arrive, then watch for strays
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
hw/rtl/psrs_pkg.sv
hw/rtl/psrs_ram.sv
hw/rtl/psrs_datapath.sv
hw/rtl/psrs_ctrl.sv
hw/rtl/prefix_sum_rank_select.sv
tb/sv/tb.sv
